/* src/assert_macros.svh */
// Concurrent assertion helpers; expect clk_i and rst_ni in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

/* src/ehc_pkg.sv */
package ehc_pkg;

  localparam int unsigned SizeW = 56;
  localparam int unsigned IdW   = 32;
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [SizeW-1:0] MaxClusterSizeReset = SizeW'(64 * 1024 * 1024);

  localparam logic [7:0]     VoidId    = 8'hEC;
  localparam logic [IdW-1:0] ClusterId = 32'h1F43B675;

  localparam int unsigned NumKnownIds = 10;
  localparam logic [IdW-1:0] KnownIds [NumKnownIds] = '{
    32'h1A45DFA3, 32'h18538067, 32'h114D9B74, 32'h1549A966, 32'h1654AE6B,
    32'h1F43B675, 32'h1C53BB6B, 32'h1043A770, 32'h1254C367, 32'h1941A469
  };

  localparam logic [2:0] VerdictVoid        = 3'd0;
  localparam logic [2:0] VerdictKnown       = 3'd1;
  localparam logic [2:0] VerdictClusterSane = 3'd2;
  localparam logic [2:0] VerdictClusterOpen = 3'd3;
  localparam logic [2:0] VerdictNeedMore    = 3'd4;
  localparam logic [2:0] VerdictUnknownId   = 3'd5;
  localparam logic [2:0] VerdictBadSize     = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_flag;
    logic       last_flag;
  } in_beat_t;

  typedef struct packed {
    logic             plausible;
    logic [2:0]       verdict_code;
    logic [IdW-1:0]   element_id;
    logic [SizeW-1:0] declared_size;
  } out_beat_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_flag;
    logic       last_flag;
    logic       is_void;
    logic       is_zero;
    logic       is_ff;
    logic [2:0] extra;
    logic [6:0] low_bits;
    logic       low_ones;
  } class_t;

  function automatic logic id_is_known(logic [IdW-1:0] id);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NumKnownIds; i++) begin
      if (KnownIds[i] == id) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

/* src/ehc_stream_if.sv */
interface ehc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* src/ebml_top_level_header_check.sv */
// Top-level EBML element header check.
// in_i carries one buffer byte per beat with start_flag (first byte of a
// candidate element) and last_flag (last byte available now). out_o gives
// one verdict per candidate: plausible, verdict_code, element_id and the
// declared Cluster size. Beats without start_flag after a verdict are
// dropped; start_flag in the middle of a check abandons it silently.
// cfg_we_i/cfg_wdata_i load the largest sane Cluster size; write it only
// while no check is in flight.
// Throughput: one byte per cycle while out_o is not stalled, set by the
// parser step in the back end. Path: the beat that decides a verdict is
// written into the queue when accepted, then the parser step moves the
// verdict into the output register when it pops that beat from the queue.
// Reset: the size limit returns to 64 MiB and the parser waits for a
// start beat. When out_o stalls, the verdict holds, the parser stops, and
// the queue takes up to QueueDepth more beats before in_i.ready drops.
module ebml_top_level_header_check #(
  parameter int unsigned QueueDepth = ehc_pkg::QueueDepthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  ehc_stream_if.sink                in_i,
  ehc_stream_if.source              out_o,
  input  logic                      cfg_we_i,
  input  logic [ehc_pkg::SizeW-1:0] cfg_wdata_i
);
  import ehc_pkg::*;

  logic   push, full, pop, head_valid;
  class_t cls, head;

  ehc_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cls_o  (cls)
  );

  ehc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cls),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (head)
  );

  ehc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

/* src/ehc_front.sv */
module ehc_front (
  ehc_stream_if.sink     in_i,
  input  logic           full_i,
  output logic           push_o,
  output ehc_pkg::class_t cls_o
);
  import ehc_pkg::*;

  function automatic logic [2:0] lead_zeros(logic [7:0] b);
    logic [2:0] n;
    n = 3'd7;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        n = 3'(7 - i);
      end
    end
    return n;
  endfunction

  logic [7:0] b;
  logic [2:0] extra;
  logic [6:0] low_mask;

  assign b        = in_i.payload.data_byte;
  assign extra    = lead_zeros(b);
  assign low_mask = 7'h7F >> extra;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    cls_o.data_byte  = b;
    cls_o.start_flag = in_i.payload.start_flag;
    cls_o.last_flag  = in_i.payload.last_flag;
    cls_o.is_void    = (b == VoidId);
    cls_o.is_zero    = (b == 8'h00);
    cls_o.is_ff      = (b == 8'hFF);
    cls_o.extra      = extra;
    cls_o.low_bits   = b[6:0] & low_mask;
    cls_o.low_ones   = (b[6:0] & low_mask) == low_mask;
  end

endmodule

/* src/ehc_fifo.sv */
`include "assert_macros.svh"

module ehc_fifo #(
  parameter int unsigned Depth = ehc_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ehc_pkg::class_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output ehc_pkg::class_t data_o
);
  import ehc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  class_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `ASSERT_NEVER(a_no_overflow, push_i && full_o, "queue push while full")
  `ASSERT_NEVER(a_no_underflow, pop_i && !valid_o, "queue pop while empty")

endmodule

/* src/ehc_back.sv */
`include "assert_macros.svh"

module ehc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ehc_pkg::SizeW-1:0]   cfg_wdata_i,
  input  logic                        head_valid_i,
  input  ehc_pkg::class_t             head_i,
  output logic                        pop_o,
  ehc_stream_if.source                out_o
);
  import ehc_pkg::*;

  logic [SizeW-1:0] max_q;
  logic [3:0]       idx_q, idx_d;
  logic [IdW-1:0]   id_q, id_d;
  logic [SizeW-1:0] size_q, size_d;
  logic [2:0]       left_q, left_d;
  logic             ones_q, ones_d;
  logic             decided_q, decided_d;
  logic             out_valid_q;
  out_beat_t        out_q, res;

  logic       take;
  logic       fire;
  logic [2:0] code;
  logic [SizeW-1:0] dsize;
  logic       plaus_ok;

  assign take  = head_valid_i && (!out_valid_q || out_o.ready);
  assign pop_o = take;

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  assign plaus_ok = (out_q.plausible == (out_q.verdict_code < VerdictUnknownId));

  always_comb begin
    idx_d     = idx_q;
    id_d      = id_q;
    size_d    = size_q;
    left_d    = left_q;
    ones_d    = ones_q;
    decided_d = decided_q;
    fire      = 1'b0;
    code      = VerdictNeedMore;
    dsize     = '0;
    if (take) begin
      if (head_i.start_flag) begin
        idx_d     = '0;
        id_d      = '0;
        size_d    = '0;
        left_d    = '0;
        ones_d    = 1'b1;
        decided_d = 1'b0;
      end
      if (!decided_d) begin
        if (idx_d[3:2] == 2'b00) begin
          if (idx_d == 4'd0 && head_i.is_void) begin
            fire = 1'b1;
            code = VerdictVoid;
          end else begin
            id_d = {id_d[IdW-9:0], head_i.data_byte};
          end
          idx_d = idx_d + 1'b1;
        end else if (idx_d == 4'd4) begin
          idx_d = 4'd5;
          if (!id_is_known(id_d)) begin
            fire = 1'b1;
            code = VerdictUnknownId;
          end else if (id_d != ClusterId) begin
            fire = 1'b1;
            code = VerdictKnown;
          end else if (head_i.is_zero) begin
            fire = 1'b1;
            code = VerdictBadSize;
          end else begin
            size_d = SizeW'(head_i.low_bits);
            ones_d = head_i.low_ones;
            left_d = head_i.extra;
            if (head_i.extra == 3'd0) begin
              fire  = 1'b1;
              code  = ones_d ? VerdictClusterOpen
                             : ((size_d <= max_q) ? VerdictClusterSane : VerdictBadSize);
              dsize = size_d;
            end
          end
        end else begin
          size_d = {size_d[SizeW-9:0], head_i.data_byte};
          ones_d = ones_d && head_i.is_ff;
          if (left_d != 3'd0) begin
            left_d = left_d - 1'b1;
          end
          if (left_d == 3'd0) begin
            fire  = 1'b1;
            code  = ones_d ? VerdictClusterOpen
                           : ((size_d <= max_q) ? VerdictClusterSane : VerdictBadSize);
            dsize = size_d;
          end
          if (idx_d != 4'd15) begin
            idx_d = idx_d + 1'b1;
          end
        end
        if (!fire && head_i.last_flag) begin
          fire  = 1'b1;
          code  = VerdictNeedMore;
          dsize = '0;
        end
        if (fire) begin
          decided_d = 1'b1;
        end
      end
    end
  end

  always_comb begin
    res.plausible     = (code != VerdictUnknownId) && (code != VerdictBadSize);
    res.verdict_code  = code;
    res.element_id    = (code != VerdictVoid && (idx_d[3] || idx_d[2])) ? id_d : '0;
    res.declared_size = dsize;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= MaxClusterSizeReset;
      idx_q       <= '0;
      id_q        <= '0;
      size_q      <= '0;
      left_q      <= '0;
      ones_q      <= 1'b1;
      decided_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      idx_q     <= idx_d;
      id_q      <= id_d;
      size_q    <= size_d;
      left_q    <= left_d;
      ones_q    <= ones_d;
      decided_q <= decided_d;
      if (take && fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && fire) begin
      out_q <= res;
    end
  end

  `ASSERT_RST(a_plausible_code, out_valid_q |-> plaus_ok, "plausible disagrees with verdict")
  `ASSERT_RST(a_result_after_take, $rose(out_valid_q) |-> $past(take), "result without a beat")

endmodule
